// ===== hw/rtl/ptts_pkg.sv =====
// Shared types, codes and constants for the periodic task tick scheduler.
package ptts_pkg;

    // Widths and sizes
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int SLOTS      = 4;

    // Defaults for top-level parameters
    localparam int TASKS_DEF     = 4;
    localparam int TICK_STEP_DEF = 1;

    // Reset values
    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd100;
    localparam logic [CNT_W-1:0] COUNT_RST  = 16'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BASE  = 8'd4;

    // Request codes
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_DELETE  = 2'd1;
    localparam logic [1:0] REQ_SUSPEND = 2'd2;
    localparam logic [1:0] REQ_RESUME  = 2'd3;

    // Status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // Input word
    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] task_index;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic       fired;
        logic [1:0] task_id;
        logic       status;
        logic       last;
    } out_word_t;

    // Per-cell command bundle from the controller
    typedef struct packed {
        logic             wr_period;
        logic             wr_first;
        logic             clr_present;
        logic             clr_running;
        logic             set_running;
        logic [CNT_W-1:0] wdata;
    } cell_cmd_t;

    // Per-cell status back to the controller
    typedef struct packed {
        logic present;
        logic fire;
    } cell_stat_t;

endpackage

// ===== hw/rtl/periodic_task_tick_scheduler_top.sv =====
// Top level: request decode, cell chain and result sequencing.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | start, busy, req                        | taken when start && !busy
//  result   | result_valid, result                    | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| taken when valid && ready
//
// A delete, suspend or resume does not raise busy; its word appears the next cycle.
// A tick passes a token down the chain, one cell per cycle, then a closing
// cycle, busy all the while. Each fired word but the last is strobed the
// cycle after the next firing; the last is carried by the closing word,
// which lands in the same cycle that busy falls.
// Reset loads each countdown with zero, periods with 100, all tasks live.
// The receiver cannot stall; results are never held back.
module periodic_task_tick_scheduler_top #(
    parameter int TASKS     = ptts_pkg::TASKS_DEF,
    parameter int TICK_STEP = ptts_pkg::TICK_STEP_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ptts_pkg::in_word_t                  req,
    output logic                                result_valid,
    output ptts_pkg::out_word_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptts_pkg::CNT_W-1:0]          cfg_data
);
    import ptts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;

    logic [1:0]  state_reg, state_next;
    logic        tok_start_reg, tok_start_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [1:0]  pend_id_reg, pend_id_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;

    logic [TASKS:0]   tok;
    cell_cmd_t        cmd  [TASKS];
    cell_stat_t       stat [TASKS];
    logic             accept;
    logic             fire_any;
    logic [1:0]       fire_id;
    logic             sel_present;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign tok[0]    = tok_start_reg;

    // Cell chain
    for (genvar i = 0; i < TASKS; i++)
    begin : g_cell
        always_comb
        begin
            cmd[i].wdata       = cfg_data;
            cmd[i].wr_period   = cfg_valid && (cfg_index == CFG_PERIOD_BASE + CFG_IDX_W'(i));
            cmd[i].wr_first    = cfg_valid && (cfg_index == CFG_FIRST_BASE + CFG_IDX_W'(i));
            cmd[i].clr_present = accept && (req.req_type == REQ_DELETE)
                                 && (req.task_index == 3'(i)) && stat[i].present;
            cmd[i].clr_running = accept && (req.req_type == REQ_SUSPEND)
                                 && (req.task_index == 3'(i)) && stat[i].present;
            cmd[i].set_running = accept && (req.req_type == REQ_RESUME)
                                 && (req.task_index == 3'(i)) && stat[i].present;
        end

        ptts_cell #(
            .TICK_STEP (TICK_STEP)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd[i]),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .stat    (stat[i])
        );
    end

    // Fire detect and presence lookup
    always_comb
    begin
        fire_any    = 1'b0;
        fire_id     = '0;
        sel_present = 1'b0;
        for (int i = 0; i < TASKS; i++)
        begin
            if (stat[i].fire)
            begin
                fire_any = 1'b1;
                fire_id  = 2'(i);
            end
            if (req.task_index == 3'(i))
            begin
                sel_present = stat[i].present;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        tok_start_next  = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_TICK)
                    begin
                        tok_start_next  = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        out_next.fired   = 1'b0;
                        out_next.task_id = '0;
                        out_next.status  = sel_present ? ST_OK : ST_ERR;
                        out_next.last    = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // Hold each firing until the next one so the last word can be flagged
                if (fire_any)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_next.fired   = 1'b1;
                        out_next.task_id = pend_id_reg;
                        out_next.status  = ST_OK;
                        out_next.last    = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = fire_id;
                end
                // Closing cycle after the last cell
                if (tok[TASKS])
                begin
                    out_valid_next   = 1'b1;
                    out_next.fired   = pend_valid_reg;
                    out_next.task_id = pend_valid_reg ? pend_id_reg : 2'd0;
                    out_next.status  = ST_OK;
                    out_next.last    = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tok_start_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tok_start_reg  <= tok_start_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== hw/rtl/ptts_cell.sv =====
// One task cell: countdown, period, flags, and the scan token stage.
module ptts_cell #(
    parameter int TICK_STEP = ptts_pkg::TICK_STEP_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ptts_pkg::cell_cmd_t cmd,
    input  logic                tok_in,
    output logic                tok_out,
    output ptts_pkg::cell_stat_t stat
);
    import ptts_pkg::*;

    localparam logic [CNT_W-1:0] STEP = CNT_W'(TICK_STEP);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] period_reg, period_next;
    logic             present_reg, present_next;
    logic             running_reg, running_next;
    logic             tok_reg;
    logic             fire;
    logic [CNT_W-1:0] dec;

    // Fire when the token visits a live task at zero
    assign fire = tok_in && present_reg && running_reg && (cnt_reg == '0);

    // Saturating countdown with the 1 -> 2 bump
    always_comb
    begin
        dec = (cnt_reg > STEP) ? (cnt_reg - STEP) : '0;
        if (dec == CNT_W'(1))
        begin
            dec = CNT_W'(2);
        end
    end

    // Next-state logic
    always_comb
    begin
        cnt_next     = cnt_reg;
        period_next  = period_reg;
        present_next = present_reg;
        running_next = running_reg;
        if (cmd.wr_period)
        begin
            period_next = cmd.wdata;
        end
        if (cmd.clr_present)
        begin
            present_next = 1'b0;
        end
        if (cmd.clr_running)
        begin
            running_next = 1'b0;
        end
        if (cmd.set_running)
        begin
            running_next = 1'b1;
        end
        priority if (cmd.wr_first)
        begin
            cnt_next = cmd.wdata;
        end
        else if (fire)
        begin
            cnt_next = period_reg;
        end
        else if (tok_in)
        begin
            cnt_next = dec;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= COUNT_RST;
            period_reg  <= PERIOD_RST;
            present_reg <= 1'b1;
            running_reg <= 1'b1;
            tok_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            period_reg  <= period_next;
            present_reg <= present_next;
            running_reg <= running_next;
            tok_reg     <= tok_in;
        end
    end

    assign tok_out      = tok_reg;
    assign stat.present = present_reg;
    assign stat.fire    = fire;

endmodule

// ===== test/periodic_task_tick_scheduler_top_tb.sv =====
// Self-checking testbench for the periodic task tick scheduler top level.
module periodic_task_tick_scheduler_top_tb;
    import ptts_pkg::*;

    localparam int TASKS      = TASKS_DEF;
    localparam int TICK_STEP  = TICK_STEP_DEF;
    localparam int QUIET_MAX  = 2000;
    localparam int PHASES     = 7;
    localparam int PHASE_REQS = 27;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    in_word_t             req = '0;
    logic                 result_valid;
    out_word_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data = '0;

    // Scheduler shadow state
    logic [CNT_W-1:0] period_sh [SLOTS];
    logic [CNT_W-1:0] first_sh  [SLOTS];
    logic [CNT_W-1:0] count_sh  [SLOTS];
    bit               present_sh [SLOTS];
    bit               running_sh [SLOTS];

    in_word_t  pending_reqs [$];
    out_word_t due_words [$];

    int  n_queued = 0;
    int  n_taken = 0;
    int  n_words = 0;
    int  n_fired = 0;
    int  n_cfg = 0;
    int  n_errors = 0;
    int  gap_left = 0;
    int  quiet = 0;
    bit  idle_en = 1'b1;

    periodic_task_tick_scheduler_top #(
        .TASKS     (TASKS),
        .TICK_STEP (TICK_STEP)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register write into the shadow copy
    task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        if (idx < CFG_FIRST_BASE)
        begin
            period_sh[idx[1:0]] = val;
        end
        else if (idx < CFG_FIRST_BASE + CFG_IDX_W'(SLOTS))
        begin
            first_sh[idx[1:0]] = val;
            count_sh[idx[1:0]] = val;
        end
    endtask

    // Advance the shadow scheduler by one request, queue the words it yields
    task automatic schedule_step(input in_word_t w);
        out_word_t ow [SLOTS];
        int        n;
        int        c;
        out_word_t e;
        n = 0;
        e = '0;
        if (w.req_type == REQ_TICK)
        begin
            for (int i = 0; i < TASKS; i++)
            begin
                if (present_sh[i] && running_sh[i] && count_sh[i] == '0)
                begin
                    count_sh[i] = period_sh[i];
                    ow[n] = '0;
                    ow[n].fired = 1'b1;
                    ow[n].task_id = i[1:0];
                    ow[n].status = ST_OK;
                    n++;
                end
                else
                begin
                    c = int'(count_sh[i]);
                    c = (c > TICK_STEP) ? c - TICK_STEP : 0;
                    // a count landing on one is pushed back to two
                    if (c == 1)
                        c = 2;
                    count_sh[i] = c[CNT_W-1:0];
                end
            end
            if (n == 0)
            begin
                e.last = 1'b1;
                due_words.push_back(e);
            end
            else
            begin
                ow[n-1].last = 1'b1;
                for (int k = 0; k < n; k++)
                    due_words.push_back(ow[k]);
            end
        end
        else
        begin
            e.last = 1'b1;
            if (int'(w.task_index) >= TASKS || !present_sh[w.task_index[1:0]])
            begin
                e.status = ST_ERR;
            end
            else
            begin
                e.status = ST_OK;
                case (w.req_type)
                    REQ_DELETE:  present_sh[w.task_index[1:0]] = 1'b0;
                    REQ_SUSPEND: running_sh[w.task_index[1:0]] = 1'b0;
                    default:     running_sh[w.task_index[1:0]] = 1'b1;
                endcase
            end
            due_words.push_back(e);
        end
    endtask

    // Request driver with random idle bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                req <= pending_reqs.pop_front();
                start <= 1'b1;
                if (idle_en && $urandom_range(0, 2) == 0)
                    gap_left <= $urandom_range(1, 4);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check result words, predict accepted requests, track writes
    always @(posedge clk)
    begin : monitor
        out_word_t w;
        if (rst_n)
        begin
            if (result_valid)
            begin
                n_words++;
                if (result.fired)
                    n_fired++;
                if (due_words.size() == 0)
                begin
                    $error("unexpected result word %p", result);
                    n_errors++;
                end
                else
                begin
                    w = due_words.pop_front();
                    if (result.fired !== w.fired)
                    begin
                        $error("fired: expected %0d, got %0d", w.fired, result.fired);
                        n_errors++;
                    end
                    if (result.task_id !== w.task_id)
                    begin
                        $error("task_id: expected %0d, got %0d", w.task_id, result.task_id);
                        n_errors++;
                    end
                    if (result.status !== w.status)
                    begin
                        $error("status: expected %0d, got %0d", w.status, result.status);
                        n_errors++;
                    end
                    if (result.last !== w.last)
                    begin
                        $error("last: expected %0d, got %0d", w.last, result.last);
                        n_errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                n_taken++;
                schedule_step(req);
            end
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                load_register(cfg_index, cfg_data);
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_MAX)
            begin
                $display("[periodic_task_tick_scheduler_top] ERROR");
                $finish;
            end
        end
    end

    task automatic queue_req(input logic [1:0] rt, input logic [2:0] ti);
        in_word_t w;
        w.req_type = rt;
        w.task_index = ti;
        pending_reqs.push_back(w);
        n_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request is taken and answered, then let the block settle
    task automatic settle();
        while (!(n_taken == n_queued && due_words.size() == 0))
            @(posedge clk);
        repeat (TASKS + 4) @(posedge clk);
    endtask

    // Counts biased toward the values that let tasks actually fire
    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0, 1:    return 16'd0;
            2:       return 16'd1;
            3:       return CNT_W'($urandom_range(2, 3));
            4:       return CNT_W'($urandom_range(0, 6));
            5:       return 16'hFFFF;
            6:       return CNT_W'($urandom_range(0, 65535));
            default: return CNT_W'($urandom_range(3, 20));
        endcase
    endfunction

    // Random request; real deletes only when allowed, else out-of-range ones
    task automatic queue_random(input bit allow_delete);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            queue_req(REQ_TICK, 3'($urandom_range(0, 7)));
        else if (r < 75)
            queue_req(REQ_SUSPEND, 3'($urandom_range(0, 7)));
        else if (r < 90)
            queue_req(REQ_RESUME, 3'($urandom_range(0, 7)));
        else if (allow_delete)
            queue_req(REQ_DELETE, 3'($urandom_range(0, 7)));
        else
            queue_req(REQ_DELETE, 3'($urandom_range(TASKS, 7)));
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            period_sh[i] = PERIOD_RST;
            first_sh[i] = COUNT_RST;
            count_sh[i] = COUNT_RST;
            present_sh[i] = 1'b1;
            running_sh[i] = 1'b1;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: all tasks fire at once, then range and redundant cases
        queue_req(REQ_TICK, 3'd7);
        queue_req(REQ_TICK, 3'd0);
        queue_req(REQ_SUSPEND, 3'd0);
        queue_req(REQ_SUSPEND, 3'd0);
        queue_req(REQ_RESUME, 3'd0);
        queue_req(REQ_RESUME, 3'd1);
        queue_req(REQ_DELETE, 3'd4);
        queue_req(REQ_DELETE, 3'd7);
        queue_req(REQ_SUSPEND, 3'd5);
        queue_req(REQ_RESUME, 3'd6);
        settle();

        // Extreme settings, plus writes to unused indexes
        write_reg(CFG_PERIOD_BASE + CFG_IDX_W'(0), 16'd0);
        write_reg(CFG_PERIOD_BASE + CFG_IDX_W'(1), 16'd1);
        write_reg(CFG_PERIOD_BASE + CFG_IDX_W'(2), 16'hFFFF);
        write_reg(CFG_PERIOD_BASE + CFG_IDX_W'(3), 16'd0);
        write_reg(CFG_FIRST_BASE + CFG_IDX_W'(0), 16'd0);
        write_reg(CFG_FIRST_BASE + CFG_IDX_W'(1), 16'd1);
        write_reg(CFG_FIRST_BASE + CFG_IDX_W'(2), 16'd0);
        write_reg(CFG_FIRST_BASE + CFG_IDX_W'(3), 16'hFFFF);
        write_reg(8'd8, 16'h5A5A);
        write_reg(8'hFF, 16'hFFFF);
        queue_req(REQ_TICK, 3'd0);
        queue_req(REQ_TICK, 3'd5);
        // suspended task sits at zero and fires on resume
        queue_req(REQ_SUSPEND, 3'd0);
        queue_req(REQ_TICK, 3'd0);
        queue_req(REQ_TICK, 3'd0);
        queue_req(REQ_RESUME, 3'd0);
        queue_req(REQ_TICK, 3'd2);
        queue_req(REQ_SUSPEND, 3'd6);
        settle();

        // Random phases; the last one has no idling and deletes real tasks
        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_en <= (ph < PHASES - 1);
            for (int i = 0; i < SLOTS; i++)
                write_reg(CFG_PERIOD_BASE + CFG_IDX_W'(i), pick_count());
            for (int i = 0; i < SLOTS; i++)
                write_reg(CFG_FIRST_BASE + CFG_IDX_W'(i), pick_count());
            write_reg(CFG_IDX_W'($urandom_range(8, 255)), CNT_W'($urandom_range(0, 65535)));
            for (int k = 0; k < PHASE_REQS; k++)
                queue_random(ph == PHASES - 1);
            settle();
        end

        $display("Run covered %0d requests, %0d result words (%0d fired), %0d register writes.",
                 n_taken, n_words, n_fired, n_cfg);
        $display("Settings swept from reset values through extremes and %0d random sets.",
                 PHASES);
        if (n_errors == 0 && due_words.size() == 0)
            $display("[periodic_task_tick_scheduler_top] OK");
        else
            $display("[periodic_task_tick_scheduler_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_cell.sv
hw/rtl/periodic_task_tick_scheduler_top.sv
test/periodic_task_tick_scheduler_top_tb.sv
